// ===== rtl/core/sha256_message_hasher_assert.svh =====
// Assertion macros used by the hasher top level.
`ifndef SHA256_MESSAGE_HASHER_ASSERT_SVH
`define SHA256_MESSAGE_HASHER_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define SHA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked on every rising clock edge outside reset.
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sha256_pkg.sv =====
package sha256_pkg;

    localparam int unsigned WordW = 32;
    localparam int unsigned CountW = 61;
    localparam int unsigned Rounds = 64;

    localparam logic [7:0] PadByte = 8'h80;

    localparam logic [WordW-1:0] InitH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [WordW-1:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       put_byte;   // pack the input byte and count it
        logic       pad;        // write 0x80 and clear the rest of the block
        logic       clear_blk;  // zero the whole block buffer
        logic       put_len;    // write the bit length into words 14 and 15
        logic       load_vars;  // copy hash words into the working variables
        logic       round;      // run one round
        logic [5:0] round_idx;
        logic       fold;       // add working variables into the hash words
        logic       reinit;     // reload initial hash values, clear the count
        logic [2:0] out_idx;    // digest word being shown
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [5:0] pos;        // byte position within the current block
    } t_stat;

endpackage

// ===== rtl/core/sha256_datapath.sv =====
module sha256_datapath
    import sha256_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic [7:0]       i_byte,
    output t_stat            o_stat,
    output logic [WordW-1:0] o_word
);

    logic [WordW-1:0]  r_h [8];
    logic [WordW-1:0]  r_v [8];
    logic [WordW-1:0]  r_w [16];
    logic [CountW-1:0] r_cnt;

    function automatic logic [WordW-1:0] ror(input logic [WordW-1:0] x, input int n);
        ror = (x >> n) | (x << (WordW - n));
    endfunction

    logic [5:0]       pos;
    logic [3:0]       t4;
    logic [WordW-1:0] w2, w15, w_new, w_use, t1, t2, e, a;
    logic [WordW-1:0] s0, s1, big0, big1, ch, maj;
    logic [4:0]       sh;
    logic [WordW-1:0] keep;
    logic [63:0]      bits;

    assign pos = r_cnt[5:0];
    assign o_stat.pos = pos;
    assign t4 = i_cmd.round_idx[3:0];
    assign w2 = r_w[4'(t4 - 4'd2)];
    assign w15 = r_w[4'(t4 - 4'd15)];
    assign s1 = ror(w2, 17) ^ ror(w2, 19) ^ (w2 >> 10);
    assign s0 = ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3);
    assign w_new = s1 + r_w[4'(t4 - 4'd7)] + s0 + r_w[t4];
    assign w_use = (i_cmd.round_idx < 6'd16) ? r_w[t4] : w_new;
    assign e = r_v[4];
    assign a = r_v[0];
    assign big1 = ror(e, 6) ^ ror(e, 11) ^ ror(e, 25);
    assign big0 = ror(a, 2) ^ ror(a, 13) ^ ror(a, 22);
    assign ch = (e & r_v[5]) ^ (~e & r_v[6]);
    assign maj = (a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t1 = r_v[7] + big1 + ch + RoundK[i_cmd.round_idx] + w_use;
    assign t2 = big0 + maj;
    // Byte lane shift: (3 - lane) * 8, with 3 - lane taken as the inverted lane bits.
    assign sh = {~pos[1:0], 3'b000};
    assign keep = (sh == 5'd24) ? '0 : (32'hffffffff << (sh + 5'd8));
    assign bits = {r_cnt, 3'b000};
    assign o_word = r_h[i_cmd.out_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            for (int j = 0; j < 8; j++) r_h[j] <= InitH[j];
        end else begin
            if (i_cmd.put_byte) begin
                r_w[pos[5:2]] <= (r_w[pos[5:2]] & ~(32'hff << sh))
                               | (WordW'(i_byte) << sh);
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.pad) begin
                r_w[pos[5:2]] <= (r_w[pos[5:2]] & keep) | (WordW'(PadByte) << sh);
                for (int j = 0; j < 16; j++)
                    if (4'(j) > pos[5:2]) r_w[j] <= '0;
            end
            if (i_cmd.clear_blk)
                for (int j = 0; j < 16; j++) r_w[j] <= '0;
            if (i_cmd.put_len) begin
                r_w[14] <= bits[63:32];
                r_w[15] <= bits[31:0];
            end
            if (i_cmd.load_vars)
                for (int j = 0; j < 8; j++) r_v[j] <= r_h[j];
            if (i_cmd.round) begin
                if (i_cmd.round_idx >= 6'd16) r_w[t4] <= w_new;
                r_v[7] <= r_v[6];
                r_v[6] <= r_v[5];
                r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2];
                r_v[2] <= r_v[1];
                r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
            end
            if (i_cmd.fold)
                for (int j = 0; j < 8; j++) r_h[j] <= r_h[j] + r_v[j];
            if (i_cmd.reinit) begin
                r_cnt <= '0;
                for (int j = 0; j < 8; j++) r_h[j] <= InitH[j];
            end
        end
    end

endmodule

// ===== rtl/core/sha256_ctrl.sv =====
module sha256_ctrl
    import sha256_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  logic i_last_byte,
    input  logic i_empty_message,
    input  t_stat i_stat,
    output t_cmd o_cmd,
    output logic o_valid,
    input  logic i_stall,
    output logic [2:0] o_word_index,
    output logic o_last_word
);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_ROUND, S_FOLD, S_PAD, S_LEN, S_OUT, S_REINIT
    } t_state;

    t_state     r_state, n_state;
    logic [5:0] r_t, n_t;
    logic [2:0] r_idx, n_idx;
    logic       r_fin, n_fin;   // message ends after the running compression
    logic       r_two, n_two;   // padding needs a second block
    logic       r_pend, n_pend; // final byte filled a block; padding follows it
    logic       acc;

    assign o_stall = (r_state != S_IDLE);
    assign acc = i_valid && (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_word_index = r_idx;
    assign o_last_word = (r_idx == 3'd7);

    always_comb begin
        n_state = r_state;
        n_t = r_t;
        n_idx = r_idx;
        n_fin = r_fin;
        n_two = r_two;
        n_pend = r_pend;
        o_cmd = '0;
        o_cmd.round_idx = r_t;
        o_cmd.out_idx = r_idx;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (i_empty_message) begin
                        n_state = S_PAD;
                    end else begin
                        o_cmd.put_byte = 1'b1;
                        if (i_stat.pos == 6'd63) begin
                            n_state = S_LOAD;
                            n_fin = 1'b0;
                            n_pend = i_last_byte;
                            n_two = 1'b0;
                        end else if (i_last_byte) begin
                            n_state = S_PAD;
                        end
                    end
                end
            end
            S_PAD: begin
                o_cmd.pad = 1'b1;
                n_fin = 1'b1;
                n_two = (i_stat.pos >= 6'd56);
                n_state = (i_stat.pos >= 6'd56) ? S_LOAD : S_LEN;
            end
            S_LEN: begin
                o_cmd.put_len = 1'b1;
                n_two = 1'b0;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load_vars = 1'b1;
                n_t = '0;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_t = r_t + 1'b1;
                if (r_t == 6'(Rounds - 1)) n_state = S_FOLD;
            end
            S_FOLD: begin
                o_cmd.fold = 1'b1;
                n_idx = '0;
                if (!r_fin) begin
                    // A final byte that completed a block still needs a padding block.
                    n_state = r_pend ? S_PAD : S_IDLE;
                    n_pend = 1'b0;
                end else if (r_two) begin
                    o_cmd.clear_blk = 1'b1;
                    n_state = S_LEN;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_idx = r_idx + 1'b1;
                    if (r_idx == 3'd7) n_state = S_REINIT;
                end
            end
            S_REINIT: begin
                o_cmd.reinit = 1'b1;
                n_fin = 1'b0;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_t <= '0;
            r_idx <= '0;
            r_fin <= 1'b0;
            r_two <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            r_state <= n_state;
            r_t <= n_t;
            r_idx <= n_idx;
            r_fin <= n_fin;
            r_two <= n_two;
            r_pend <= n_pend;
        end
    end

endmodule

// ===== rtl/core/sha256_message_hasher.sv =====
// A byte that fills a block starts a 64-round compression; a final byte is followed
// by padding and one or two 64-round compressions before the first digest word.
// Throughput: one byte per cycle within a block, while o_stall holds input off during
// each compression; the digest leaves at one word per unstalled cycle.
// Reset (i_rst_n, synchronous, active low) loads the initial hash values, clears the
// byte count and returns the controller to idle.
`include "sha256_message_hasher_assert.svh"
module sha256_message_hasher
    import sha256_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_data_byte,
    input  logic             i_last_byte,
    input  logic             i_empty_message,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [WordW-1:0] o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_last_word
);

    // The controller sequences byte intake, padding, the 64 rounds and the
    // digest readout; the datapath holds the hash state and block buffer.
    t_cmd  cmd;
    t_stat stat;

    sha256_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_last_byte    (i_last_byte),
        .i_empty_message(i_empty_message),
        .i_stat         (stat),
        .o_cmd          (cmd),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_word_index   (o_word_index),
        .o_last_word    (o_last_word)
    );

    sha256_datapath u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd),
        .i_byte (i_data_byte),
        .o_stat (stat),
        .o_word (o_digest_word)
    );

    // An item is never taken while a digest is being shown.
    `SHA_ASSERT_IMPL(a_no_take_in_out, i_clk, i_rst_n, o_valid, o_stall, "input open during readout")
    // After the final word is taken, the next cycle shows no word.
    `SHA_ASSERT_NEXT(a_end_out, i_clk, i_rst_n, o_valid && !i_stall && o_last_word, !o_valid, "extra digest word")
    // A taken word advances the index.
    `SHA_ASSERT_NEXT(a_idx_step, i_clk, i_rst_n, o_valid && !i_stall && !o_last_word, o_valid && (o_word_index == $past(o_word_index) + 3'd1), "index skip")

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    import sha256_pkg::*;

    // One input item as the driver sees it.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       empty;
        logic       hold;    // wait until every digest word has arrived before this item
    } byte_item_t;

    // One digest word as the monitor expects it.
    typedef struct packed {
        logic [WordW-1:0] word;
        logic [2:0]       index;
        logic             last;
    } digest_word_t;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    logic [7:0]       i_data_byte;
    logic             i_last_byte;
    logic             i_empty_message;
    logic             o_valid;
    logic             i_stall;
    logic [WordW-1:0] o_digest_word;
    logic [2:0]       o_word_index;
    logic             o_last_word;

    sha256_message_hasher dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .i_empty_message (i_empty_message),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_digest_word   (o_digest_word),
        .o_word_index    (o_word_index),
        .o_last_word     (o_last_word)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    byte_item_t   pending_bytes[$];
    digest_word_t expected_digest[$];
    int           error_count = 0;
    bit           stimulus_done = 1'b0;

    // The predictor keeps its own copy of the hasher state.
    logic [WordW-1:0]  hash_state[8];
    logic [WordW-1:0]  msg_block[16];
    logic [CountW-1:0] msg_bytes;

    function automatic logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // One 64-round compression of msg_block into hash_state. The schedule rolls
    // through msg_block in place, the same way the hardware keeps it.
    task automatic compress_block();
        logic [31:0] v[8];
        logic [31:0] w, t1, t2, w2, w15, sig0, sig1;
        for (int j = 0; j < 8; j++) v[j] = hash_state[j];
        for (int t = 0; t < 64; t++) begin
            if (t < 16) begin
                w = msg_block[t];
            end else begin
                w2   = msg_block[(t - 2) & 15];
                w15  = msg_block[(t - 15) & 15];
                sig1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
                sig0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
                w = sig1 + msg_block[(t - 7) & 15] + sig0 + msg_block[t & 15];
                msg_block[t & 15] = w;
            end
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + w;
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++) hash_state[j] += v[j];
    endtask

    // Padding, length and the final one or two compressions; queues the eight digest words and reinitialises the state.
    task automatic finish_message();
        int          pos;
        logic [63:0] bit_len;
        digest_word_t d;
        pos = int'(msg_bytes[5:0]);
        bit_len = {msg_bytes, 3'b000};
        for (int b = pos; b < 64; b++)
            msg_block[b / 4][(3 - b % 4) * 8 +: 8] = (b == pos) ? PadByte : 8'h00;
        if (pos >= 56) begin
            compress_block();
            for (int j = 0; j < 16; j++) msg_block[j] = '0;
        end
        msg_block[14] = bit_len[63:32];
        msg_block[15] = bit_len[31:0];
        compress_block();
        for (int j = 0; j < 8; j++) begin
            d.word  = hash_state[j];
            d.index = 3'(j);
            d.last  = (j == 7);
            expected_digest.push_back(d);
        end
        for (int j = 0; j < 8; j++) hash_state[j] = InitH[j];
        msg_bytes = '0;
    endtask

    task automatic absorb_item(byte_item_t it);
        int pos;
        if (it.empty) begin
            finish_message();
        end else begin
            pos = int'(msg_bytes[5:0]);
            msg_block[pos / 4][(3 - pos % 4) * 8 +: 8] = it.data;
            msg_bytes = msg_bytes + 1'b1;
            if (pos == 63) compress_block();
            if (it.last) finish_message();
        end
    endtask

    // Driver: presents one item at a time, with random idle gaps between items;
    // the payload holds while the block stalls.
    int send_gap = 0;
    always @(posedge i_clk) begin
        byte_item_t nxt;
        int         gap;
        bit         took;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap <= $urandom_range(0, 7);
        end else begin
            took = i_valid && !o_stall;
            gap = send_gap;
            if (took) begin
                absorb_item(pending_bytes.pop_front());
                gap = $urandom_range(0, 7);
            end
            if (i_valid && !took) begin
                // Stalled: the item stays on the bus unchanged.
            end else if (pending_bytes.size() == 0) begin
                i_valid <= 1'b0;
            end else begin
                nxt = pending_bytes[0];
                if (gap == 0 && !(nxt.hold && expected_digest.size() > 0)) begin
                    i_valid         <= 1'b1;
                    i_data_byte     <= nxt.data;
                    i_last_byte     <= nxt.last;
                    i_empty_message <= nxt.empty;
                end else begin
                    // Idle, or wait for the digest in flight to drain completely.
                    i_valid <= 1'b0;
                    send_gap <= (gap > 0) ? gap - 1 : 0;
                end
            end
        end
    end

    // Monitor: random stalls between words and a field-by-field compare.
    int recv_gap = 0;
    always @(posedge i_clk) begin
        digest_word_t want;
        int           gap;
        if (!i_rst_n) begin
            i_stall <= 1'b1;
            recv_gap <= $urandom_range(0, 7);
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_digest.size() == 0) begin
                    $error("unexpected digest word %h", o_digest_word);
                    error_count++;
                end else begin
                    want = expected_digest.pop_front();
                    if (o_digest_word !== want.word) begin
                        $error("digest_word expected %h actual %h", want.word, o_digest_word);
                        error_count++;
                    end
                    if (o_word_index !== want.index) begin
                        $error("word_index expected %0d actual %0d", want.index, o_word_index);
                        error_count++;
                    end
                    if (o_last_word !== want.last) begin
                        $error("last_word expected %0d actual %0d", want.last, o_last_word);
                        error_count++;
                    end
                end
                gap = $urandom_range(0, 7);
                recv_gap <= (gap > 0) ? gap - 1 : 0;
                i_stall <= (gap > 0);
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic add_item(logic [7:0] data, logic last, logic empty, logic hold = 1'b0);
        byte_item_t it;
        it.data = data; it.last = last; it.empty = empty; it.hold = hold;
        pending_bytes.push_back(it);
    endtask

    // A message of len random bytes, ended by the last-byte flag or, sometimes,
    // by a trailing empty-message item.
    task automatic add_message(int len, bit end_with_empty);
        for (int k = 0; k < len; k++)
            add_item(8'($urandom), (k == len - 1) && !end_with_empty, 1'b0);
        if (end_with_empty || len == 0) add_item(8'($urandom), 1'b0, 1'b1);
    endtask

    initial begin
        int count;
        int len;
        for (int j = 0; j < 8; j++) hash_state[j] = InitH[j];
        for (int j = 0; j < 16; j++) msg_block[j] = '0;
        msg_bytes = '0;
        i_valid = 1'b0;
        i_stall = 1'b1;
        i_data_byte = '0;
        i_last_byte = 1'b0;
        i_empty_message = 1'b0;
        i_rst_n = 1'b0;

        // Directed: empty message, empty with last set, single bytes at the
        // extremes, "abc", and a message ended by an empty item mid-stream.
        add_item(8'hff, 1'b0, 1'b1);
        add_item(8'h00, 1'b1, 1'b1);
        add_item(8'h00, 1'b1, 1'b0);
        add_item(8'hff, 1'b1, 1'b0);
        add_item("a", 1'b0, 1'b0);
        add_item("b", 1'b0, 1'b0);
        add_item("c", 1'b1, 1'b0);
        add_item(8'h55, 1'b0, 1'b0, 1'b1);
        add_item(8'haa, 1'b0, 1'b0);
        add_item(8'h00, 1'b0, 1'b1);

        // Random messages around the padding boundaries and across blocks;
        // lengths 55, 56, 63, 64 force one or two final compressions.
        count = 10;
        while (count < 400) begin
            case ($urandom_range(0, 5))
                0:       len = 55 + $urandom_range(0, 9);
                1:       len = 64 + $urandom_range(0, 70);
                default: len = $urandom_range(0, 20);
            endcase
            add_message(len, $urandom_range(0, 3) == 0);
            count += len + 1;
            if ($urandom_range(0, 9) == 0) pending_bytes[$].hold = 1'b1;
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_bytes.size() == 0 && !i_valid);
        wait (expected_digest.size() == 0);
        repeat (200) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #10000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
